// File: design/tcfd_pkg.sv
// ----------------------------------------------------------------------------
// Touch channel filter/detect package
// Shared widths, constants, types and the divide-by-ten helper for the
// four-lane capacitive touch qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfd_pkg;

    // Number of lanes carried by the channels, and how many of them are active.
    localparam int LANES    = 4;
    localparam int CHANNELS = 4;

    localparam int COUNT_W = 16;
    localparam int AVG_W   = 16;

    // 9*avg + count stays below 10 * 2^16, which fits in 20 bits.
    localparam int SUM_W = 20;

    // floor(x / 10) = (x * ceil(2^23 / 10)) >> 23 holds for every x below 2^22.
    localparam int            DIV10_SHIFT = 23;
    localparam int            PROD_W      = 2 * SUM_W;
    localparam logic [SUM_W-1:0] DIV10_MUL = SUM_W'(838861);

    localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

    typedef enum logic {
        MODE_SAMPLE    = 1'b0,
        MODE_CALIBRATE = 1'b1
    } t_mode;

    // What one lane reports for an item.
    typedef struct packed {
        logic             touched;
        logic [AVG_W-1:0] average;
    } t_lane_res;

    typedef t_lane_res [LANES-1:0] t_lane_vec;

    // Divide a filter sum by ten through a reciprocal multiply.
    function automatic logic [AVG_W-1:0] div10(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(DIV10_MUL);
        return prod[DIV10_SHIFT +: AVG_W];
    endfunction

endpackage

`default_nettype wire

// File: design/tcfd_if.sv
// ----------------------------------------------------------------------------
// Touch channel filter/detect interfaces
// Valid/ready channels for capture sets, results and the offset register.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcfd_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] count_0;
    logic [15:0] count_1;
    logic [15:0] count_2;
    logic [15:0] count_3;

    modport source (output valid, mode, count_0, count_1, count_2, count_3, input ready);
    modport sink   (input valid, mode, count_0, count_1, count_2, count_3, output ready);
endinterface

interface tcfd_out_if;
    logic        valid;
    logic        ready;
    logic        touched_0;
    logic        touched_1;
    logic        touched_2;
    logic        touched_3;
    logic [15:0] average_0;
    logic [15:0] average_1;
    logic [15:0] average_2;
    logic [15:0] average_3;

    modport source (output valid, touched_0, touched_1, touched_2, touched_3,
                    average_0, average_1, average_2, average_3, input ready);
    modport sink   (input valid, touched_0, touched_1, touched_2, touched_3,
                    average_0, average_1, average_2, average_3, output ready);
endinterface

interface tcfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/tcfd_lane.sv
// ----------------------------------------------------------------------------
// Touch channel lane
// One channel's IIR baseline, threshold latch and touch compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfd_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_mode,
    input  wire logic [tcfd_pkg::COUNT_W-1:0]   i_count,
    input  wire logic [tcfd_pkg::AVG_W-1:0]     i_offset,
    output tcfd_pkg::t_lane_res                 o_res
);

    logic [tcfd_pkg::AVG_W-1:0] r_avg, n_avg;
    logic [tcfd_pkg::AVG_W-1:0] r_thr, n_thr;
    logic [tcfd_pkg::SUM_W-1:0] sum;
    logic [tcfd_pkg::AVG_W:0]   thr_sum;

    always_comb begin
        // 9*avg + count, formed as 8*avg + avg + count.
        sum     = {1'b0, r_avg, 3'b000} + tcfd_pkg::SUM_W'(r_avg) + tcfd_pkg::SUM_W'(i_count);
        thr_sum = {1'b0, r_avg} + {1'b0, i_offset};
        n_avg   = r_avg;
        n_thr   = r_thr;
        unique case (tcfd_pkg::t_mode'(i_mode))
            tcfd_pkg::MODE_CALIBRATE: begin
                n_thr = thr_sum[tcfd_pkg::AVG_W] ? tcfd_pkg::AVG_MAX
                                                 : thr_sum[tcfd_pkg::AVG_W-1:0];
            end
            tcfd_pkg::MODE_SAMPLE: begin
                n_avg = tcfd_pkg::div10(sum);
            end
            default: begin
                n_avg = r_avg;
            end
        endcase
        o_res.average = n_avg;
        o_res.touched = n_avg > n_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
            r_thr <= '0;
        end else if (i_accept) begin
            r_avg <= n_avg;
            r_thr <= n_thr;
        end
    end

endmodule

`default_nettype wire

// File: design/tcfd_merge.sv
// ----------------------------------------------------------------------------
// Touch channel result merge
// Gathers the lane results into one beat and buffers it in a two-entry skid.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfd_merge (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire tcfd_pkg::t_lane_vec i_lanes,
    output logic                     o_ready,
    tcfd_out_if.source               o_out
);

    tcfd_pkg::t_lane_vec r_head, r_skid;
    logic                r_head_valid, r_skid_valid;
    logic                pop;

    assign pop     = r_head_valid & o_out.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_head_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_head <= r_skid_valid ? r_skid : i_lanes;
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid <= i_lanes;
            end else begin
                r_head <= i_lanes;
            end
        end
    end

    assign o_out.valid     = r_head_valid;
    assign o_out.touched_0 = r_head[0].touched;
    assign o_out.touched_1 = r_head[1].touched;
    assign o_out.touched_2 = r_head[2].touched;
    assign o_out.touched_3 = r_head[3].touched;
    assign o_out.average_0 = r_head[0].average;
    assign o_out.average_1 = r_head[1].average;
    assign o_out.average_2 = r_head[2].average;
    assign o_out.average_3 = r_head[3].average;

endmodule

`default_nettype wire

// File: design/touch_channel_filter_detect_top.sv
// ----------------------------------------------------------------------------
// Touch channel filter/detect top level
// Four-channel capacitive touch qualifier with IIR baseline and thresholds.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on i_in carries a mode bit and four charge-time capture counts.
// In sample mode every channel's average moves to floor((9*avg + count)/10);
// in calibrate mode every threshold is latched to average plus the offset,
// saturated at 65535. Each input beat yields exactly one beat on o_out with
// the four averages after the update and the four touched flags, where a
// channel is touched when its average is strictly above its threshold.
// The offset is written through i_cfg, which is always ready; write it only
// while no item is in flight.
// An accepted beat's results are registered in the output buffer for o_out.
// One item is taken every cycle while i_in is ready: the four lanes update
// state when it is accepted, each through one 20 by 20 bit reciprocal multiply.
// When the receiver stalls, a two-entry output skid holds results. i_in drops
// ready only while the second entry is in use, starting the cycle after a
// stalled beat, and is ready again the cycle after the receiver takes a beat.
// Reset clears averages, thresholds, the offset and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_channel_filter_detect_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tcfd_in_if.sink     i_in,
    tcfd_cfg_if.sink    i_cfg,
    tcfd_out_if.source  o_out
);

    logic [tcfd_pkg::AVG_W-1:0]   r_threshold_offset;
    logic                         merge_ready;
    logic                         accept;
    tcfd_pkg::t_lane_vec          lanes;
    logic [tcfd_pkg::COUNT_W-1:0] counts [tcfd_pkg::LANES];

    // The offset register takes a write in any cycle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_offset <= '0;
        end else if (i_cfg.valid) begin
            r_threshold_offset <= i_cfg.data;
        end
    end

    assign i_in.ready = merge_ready;
    assign accept     = i_in.valid & merge_ready;

    assign counts[0] = i_in.count_0;
    assign counts[1] = i_in.count_1;
    assign counts[2] = i_in.count_2;
    assign counts[3] = i_in.count_3;

    // Active channels get a lane; the rest report zero.
    for (genvar g = 0; g < tcfd_pkg::LANES; g++) begin : g_lane
        if (g < tcfd_pkg::CHANNELS) begin : g_on
            tcfd_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_accept (accept),
                .i_mode   (i_in.mode),
                .i_count  (counts[g]),
                .i_offset (r_threshold_offset),
                .o_res    (lanes[g])
            );
        end else begin : g_off
            assign lanes[g] = '0;
        end
    end

    tcfd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_lanes (lanes),
        .o_ready (merge_ready),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
